// ----- rtl/wrm_pkg.sv -----
// Shared types, constants and helper functions of the wildcard pattern matcher.
// Depends on nothing; the register file, front end, queue, back end and top import this package.
`default_nettype none

package wrm_pkg;

   // Pattern geometry.
   localparam int MAX_PATTERN = 16;
   localparam int ROW_W       = MAX_PATTERN + 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

   // Register file geometry.
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int LENGTH_W    = 5;

   // Register indexes, taken from address bits 4 to 3.
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

   // Special pattern bytes.
   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] DOT_BYTE  = 8'h2E;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Active pattern as seen by the datapath.
   typedef struct packed {
      logic [MAX_PATTERN-1:0][7:0] pat;
      logic [LEN_W-1:0]            len;
   } cfg_type;

   // One classified text byte: per-column hit bits plus the framing flags.
   typedef struct packed {
      logic [MAX_PATTERN:1] hit;
      logic                 first;
      logic                 last;
   } item_type;

   // Column j is a quantifier when its byte is a star and it has an element before it.
   function automatic logic [MAX_PATTERN:1] quant_mask(cfg_type cfg);
      logic [MAX_PATTERN:1] q;
      q = '0;
      for (int j = 2; j <= MAX_PATTERN; j++) begin
         q[j] = (cfg.pat[j-1] == STAR_BYTE);
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/wrm_req_if.sv -----
// Input channel of the matcher: one text byte with its framing flags per beat.
// Depends on nothing.
`default_nettype none

interface wrm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first;
   logic       last;

   modport source (output valid, text_byte, first, last, input ready);
   modport sink   (input valid, text_byte, first, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/wrm_rsp_if.sv -----
// Result channel of the matcher: one match verdict per beat.
// Depends on nothing.
`default_nettype none

interface wrm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic end_of_text;

   modport source (output valid, matched, end_of_text, input ready);
   modport sink   (input valid, matched, end_of_text, output ready);
endinterface

`default_nettype wire

// ----- rtl/wrm_csr.sv -----
// APB-style register file holding the pattern and its length.
// Depends on wrm_pkg.
`default_nettype none

module wrm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [wrm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [wrm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [wrm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output wrm_pkg::cfg_type                    cfg
);
   import wrm_pkg::*;

   logic [CSR_DATA_W-1:0]  pattern_low_ff;
   logic [CSR_DATA_W-1:0]  pattern_high_ff;
   logic [LENGTH_W-1:0]    length_ff;
   logic [CSR_INDEX_W-1:0] index;
   logic                   write_en;
   logic [2*CSR_DATA_W-1:0] pattern_all;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CSR_ADDR_W-1:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;

   // Register writes at the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         length_ff       <= '0;
      end else if (write_en) begin
         unique case (index)
            REG_PATTERN_LOW:    pattern_low_ff  <= csr_pwdata;
            REG_PATTERN_HIGH:   pattern_high_ff <= csr_pwdata;
            REG_PATTERN_LENGTH: length_ff       <= csr_pwdata[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      unique case (index)
         REG_PATTERN_LOW:    csr_prdata = pattern_low_ff;
         REG_PATTERN_HIGH:   csr_prdata = pattern_high_ff;
         REG_PATTERN_LENGTH: csr_prdata = {{(CSR_DATA_W-LENGTH_W){1'b0}}, length_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // Active pattern: bytes in order and a length clamped to the column count.
   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         cfg.pat[k] = pattern_all[8*k +: 8];
      end
      if (length_ff > LENGTH_W'(MAX_PATTERN)) begin
         cfg.len = LEN_W'(MAX_PATTERN);
      end else begin
         cfg.len = length_ff[LEN_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wrm_front.sv -----
// Front end: accepts text bytes and compares each against every pattern column.
// Depends on wrm_pkg and wrm_req_if.
`default_nettype none

module wrm_front (
   wrm_req_if.sink               req_bus,
   input  wire wrm_pkg::cfg_type cfg,
   output wrm_pkg::item_type     push_item,
   output logic                  push_valid,
   input  wire logic             push_ready
);
   import wrm_pkg::*;

   logic [MAX_PATTERN:1] quant;
   logic [7:0]           sel;

   assign quant         = quant_mask(cfg);
   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;

   // A quantifier column tests the repeated element, any other column its own byte.
   always_comb begin
      sel = '0;
      push_item.first = req_bus.first;
      push_item.last  = req_bus.last;
      push_item.hit[1] = (req_bus.text_byte == cfg.pat[0]) || (cfg.pat[0] == DOT_BYTE);
      for (int j = 2; j <= MAX_PATTERN; j++) begin
         sel = quant[j] ? cfg.pat[j-2] : cfg.pat[j-1];
         push_item.hit[j] = (req_bus.text_byte == sel) || (sel == DOT_BYTE);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wrm_queue.sv -----
// Short register queue that decouples the front end from the back end.
// Depends on wrm_pkg.
`default_nettype none

module wrm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wrm_pkg::item_type push_item,
   input  wire logic              push_valid,
   output logic                   push_ready,
   output wrm_pkg::item_type      pop_item,
   output logic                   pop_valid,
   input  wire logic              pop_ready
);
   import wrm_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wrm_back.sv -----
// Back end: advances the match row by one text position per beat and
// registers the verdict. Depends on wrm_pkg and wrm_rsp_if.
`default_nettype none

module wrm_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wrm_pkg::cfg_type  cfg,
   input  wire wrm_pkg::item_type pop_item,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   wrm_rsp_if.source              rsp_bus
);
   import wrm_pkg::*;

   logic [ROW_W-1:0]     row_ff;
   logic [ROW_W-1:0]     row_in;
   logic                 rsp_valid_ff;
   logic                 matched_ff;
   logic                 end_ff;
   logic [MAX_PATTERN:1] quant;
   logic [ROW_W-1:0]     mask;
   logic [ROW_W-1:0]     empty;
   logic [ROW_W-1:0]     prev;
   logic                 do_pop;

   assign quant     = quant_mask(cfg);
   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;
   assign do_pop    = pop_valid && pop_ready;

   // Columns in use, and the row for an empty text.
   always_comb begin
      for (int j = 0; j < ROW_W; j++) begin
         mask[j] = (LEN_W'(j) <= cfg.len);
      end
      empty    = '0;
      empty[0] = 1'b1;
      for (int j = 2; j < ROW_W; j++) begin
         empty[j] = mask[j] && quant[j] && empty[j-2];
      end
   end

   // Row update: a quantifier column takes the zero-repeat path from two
   // columns back or one more repeat of its element; other columns advance
   // the diagonal.
   always_comb begin
      prev      = pop_item.first ? empty : (row_ff & mask);
      row_in    = '0;
      row_in[1] = mask[1] && pop_item.hit[1] && prev[0];
      for (int j = 2; j < ROW_W; j++) begin
         if (quant[j]) begin
            row_in[j] = mask[j] && (row_in[j-2] || (pop_item.hit[j] && prev[j]));
         end else begin
            row_in[j] = mask[j] && pop_item.hit[j] && prev[j-1];
         end
      end
   end

   // Row state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_pop) begin
            row_ff <= row_in;
         end
         if (pop_ready) begin
            rsp_valid_ff <= pop_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         matched_ff <= row_in[cfg.len];
         end_ff     <= pop_item.last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.matched     = matched_ff;
   assign rsp_bus.end_of_text = end_ff;

endmodule

`default_nettype wire

// ----- rtl/wildcard_regex_matcher_top.sv -----
// Streaming wildcard pattern matcher: register file, front end, queue and back end.
// Depends on wrm_pkg, wrm_req_if, wrm_rsp_if, wrm_csr, wrm_front, wrm_queue, wrm_back.
//
// Usage:
//   Program the pattern over the csr_ port: pattern_low at byte address 0,
//   pattern_high at 8, pattern_length at 16 (64-bit data, pready always high).
//   Pattern bytes may use '.' for any byte and '*' to repeat the element before it.
//   Send text one byte per beat on req_bus, with first marking the byte that
//   starts a string and last the byte that ends it. Each byte gives exactly one
//   beat on rsp_bus: matched tells whether the text so far matches the whole
//   pattern, end_of_text copies last.
// Timing:
//   A result is registered in the queue and then in the output register of
//   the back end. One byte per cycle is sustained while rsp_bus.ready is high;
//   the cycle is set by the ripple of the match row across the pattern columns.
// Reset:
//   Synchronous, active high. Clears the registers, the queue and the match row,
//   so bytes before the first flagged byte never match.
// Stalls:
//   When rsp_bus.ready is low the result is held in the output register, the
//   two-entry queue fills, and req_bus.ready drops once it is full.
`default_nettype none

module wildcard_regex_matcher_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [wrm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [wrm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [wrm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   wrm_req_if.sink                             req_bus,
   wrm_rsp_if.source                           rsp_bus
);
   import wrm_pkg::*;

   cfg_type  cfg;
   item_type push_item;
   logic     push_valid;
   logic     push_ready;
   item_type pop_item;
   logic     pop_valid;
   logic     pop_ready;

   wrm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wrm_front u_front (
      .req_bus    (req_bus),
      .cfg        (cfg),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   wrm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   wrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_item  (pop_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
